// ----- design/irpd_pkg.sv -----
// shared types, constants and register codes for the ir remote pulse decoder
`timescale 1ns / 1ps

package irpd_pkg;

  // frame geometry
  localparam int EDGE_DEPTH      = 50;
  localparam int FIRST_DATA_EDGE = 17;
  localparam int DATA_BITS       = 8;

  // field widths
  localparam int TICK_W = 17;
  localparam int CMD_W  = 8;
  localparam int CNT_W  = $clog2(EDGE_DEPTH + 1);
  localparam int CMD_LOW = (DATA_BITS < CMD_W) ? DATA_BITS : CMD_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TICK_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEADER_MIN = 3'd0,
    REG_LEADER_MAX = 3'd1,
    REG_ONE_MIN    = 3'd2,
    REG_ONE_MAX    = 3'd3,
    REG_KEY_CODE_A = 3'd4,
    REG_KEY_CODE_B = 3'd5
  } cfg_reg_t;

  // register reset values
  localparam logic [TICK_W-1:0] LEADER_MIN_RST = TICK_W'(10000);
  localparam logic [TICK_W-1:0] LEADER_MAX_RST = TICK_W'(14000);
  localparam logic [TICK_W-1:0] ONE_MIN_RST    = TICK_W'(2000);
  localparam logic [TICK_W-1:0] ONE_MAX_RST    = TICK_W'(2300);
  localparam logic [CMD_W-1:0]  KEY_CODE_A_RST = CMD_W'(69);
  localparam logic [CMD_W-1:0]  KEY_CODE_B_RST = CMD_W'(70);

  // input item kinds
  localparam logic FUNC_EDGE    = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] leader_min;
    logic [TICK_W-1:0] leader_max;
    logic [TICK_W-1:0] one_min;
    logic [TICK_W-1:0] one_max;
    logic [CMD_W-1:0]  key_code_a;
    logic [CMD_W-1:0]  key_code_b;
  } cfg_t;

  // frame state seen by the result stage
  typedef struct packed {
    logic [TICK_W-1:0]    leader_interval;
    logic [DATA_BITS-1:0] bit_store;
  } frame_t;

endpackage

// ----- design/irpd_ifs.sv -----
// valid/ready channel interfaces for edge items and frame results
`timescale 1ns / 1ps

interface irpd_item_if;
  import irpd_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [TICK_W-1:0] interval_ticks;

  modport source (output valid, func, interval_ticks, input ready);
  modport sink   (input valid, func, interval_ticks, output ready);
endinterface

interface irpd_result_if;
  import irpd_pkg::*;
  logic             valid;
  logic             ready;
  logic             leader_ok;
  logic [CMD_W-1:0] command_byte;
  logic             key_seen;

  modport source (output valid, leader_ok, command_byte, key_seen, input ready);
  modport sink   (input valid, leader_ok, command_byte, key_seen, output ready);
endinterface

// ----- design/ir_remote_pulse_decoder.sv -----
// top level of the ir remote pulse decoder
`timescale 1ns / 1ps

// Decodes an NEC-style infrared frame from falling-edge intervals. Each beat on
// item is an edge (func 0, interval_ticks measured since the previous edge) or a
// frame timeout (func 1); only a timeout produces a beat on result, carrying
// leader_ok, the command byte (0 when the leader is out of its window) and the
// sticky key_seen flag. An item is registered on acceptance; an edge drains in
// the next cycle, a timeout's result goes on to the result register. One item is
// taken every cycle; the only stall comes from the single result register,
// which holds a timeout back while a previous result is still untaken.
// Configuration writes take effect on the next cycle and belong in idle time.
module ir_remote_pulse_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irpd_pkg::CFG_DATA_W-1:0]    cfg_data,
  irpd_item_if.sink                          item,
  irpd_result_if.source                      result
);
  import irpd_pkg::*;

  cfg_t              cfg;
  frame_t            frame;
  logic              in_valid;
  logic              in_func;
  logic [TICK_W-1:0] in_ticks;
  logic              can_load;
  logic              consume;
  logic              load;

  irpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // edges always drain; a timeout waits for room in the result register
  assign consume    = in_valid && ((in_func == FUNC_EDGE) || can_load);
  assign load       = consume && (in_func == FUNC_TIMEOUT);
  assign item.ready = !in_valid || consume;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_func  <= item.func;
      in_ticks <= item.interval_ticks;
    end
  end

  irpd_frame u_frame (
    .clk   (clk),
    .rst   (rst),
    .step  (consume),
    .func  (in_func),
    .ticks (in_ticks),
    .cfg   (cfg),
    .frame (frame)
  );

  irpd_result u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .frame    (frame),
    .cfg      (cfg),
    .can_load (can_load),
    .result   (result)
  );

`ifndef ASSERT_OFF
  // a pending timeout must not be overrun while the result is stalled
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && (in_func == FUNC_TIMEOUT) && result.valid && !result.ready
      |-> !item.ready)
    else $error("timeout dropped while result stalled");

  // each processed timeout shows up as a result beat
  a_timeout_result: assert property (@(posedge clk) disable iff (rst)
    load |=> result.valid)
    else $error("processed timeout gave no result");

  // an invalid leader always reports a zero command
  a_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.leader_ok |-> (result.command_byte == '0))
    else $error("command nonzero with bad leader");
`endif

endmodule

// ----- design/irpd_cfg.sv -----
// configuration register file
`timescale 1ns / 1ps

module irpd_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irpd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output irpd_pkg::cfg_t                     cfg
);
  import irpd_pkg::*;

  // register writes, out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_min <= LEADER_MIN_RST;
      cfg.leader_max <= LEADER_MAX_RST;
      cfg.one_min    <= ONE_MIN_RST;
      cfg.one_max    <= ONE_MAX_RST;
      cfg.key_code_a <= KEY_CODE_A_RST;
      cfg.key_code_b <= KEY_CODE_B_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEADER_MIN: cfg.leader_min <= TICK_W'(cfg_data);
        REG_LEADER_MAX: cfg.leader_max <= TICK_W'(cfg_data);
        REG_ONE_MIN:    cfg.one_min    <= TICK_W'(cfg_data);
        REG_ONE_MAX:    cfg.one_max    <= TICK_W'(cfg_data);
        REG_KEY_CODE_A: cfg.key_code_a <= CMD_W'(cfg_data);
        REG_KEY_CODE_B: cfg.key_code_b <= CMD_W'(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

// ----- design/irpd_frame.sv -----
// edge tracking: arming, edge counter, leader capture and data bit store
`timescale 1ns / 1ps

module irpd_frame (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          func,
  input  logic [irpd_pkg::TICK_W-1:0]   ticks,
  input  irpd_pkg::cfg_t                cfg,
  output irpd_pkg::frame_t              frame
);
  import irpd_pkg::*;

  logic                 armed, armed_next;
  logic [CNT_W-1:0]     edge_count, edge_count_next;
  logic [TICK_W-1:0]    leader_interval, leader_interval_next;
  logic [DATA_BITS-1:0] bit_store, bit_store_next;
  logic                 take, hit_one;

  // an edge counts once armed and while the store has room
  assign take    = armed && (edge_count < CNT_W'(EDGE_DEPTH));
  assign hit_one = (ticks >= cfg.one_min) && (ticks <= cfg.one_max);

  // next frame state for one beat
  always_comb begin
    armed_next           = armed;
    edge_count_next      = edge_count;
    leader_interval_next = leader_interval;
    bit_store_next       = bit_store;
    if (func == FUNC_TIMEOUT) begin
      armed_next           = 1'b0;
      edge_count_next      = '0;
      leader_interval_next = '0;
    end else if (!armed) begin
      armed_next = 1'b1;
    end else if (take) begin
      edge_count_next = edge_count + CNT_W'(1);
      if (edge_count == '0) begin
        leader_interval_next = ticks;
      end
      for (int i = 0; i < DATA_BITS; i++) begin
        if (edge_count == CNT_W'(FIRST_DATA_EDGE + i)) begin
          bit_store_next[i] = hit_one;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed           <= 1'b0;
      edge_count      <= '0;
      leader_interval <= '0;
      bit_store       <= '0;
    end else if (step) begin
      armed           <= armed_next;
      edge_count      <= edge_count_next;
      leader_interval <= leader_interval_next;
      bit_store       <= bit_store_next;
    end
  end

  assign frame.leader_interval = leader_interval;
  assign frame.bit_store       = bit_store;

endmodule

// ----- design/irpd_result.sv -----
// frame judgment, sticky key flag and result output register
`timescale 1ns / 1ps

module irpd_result (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  irpd_pkg::frame_t  frame,
  input  irpd_pkg::cfg_t    cfg,
  output logic              can_load,
  irpd_result_if.source     result
);
  import irpd_pkg::*;

  logic             valid;
  logic             key_flag, key_flag_next;
  logic             ok;
  logic [CMD_W-1:0] cmd;
  logic             leader_ok;
  logic [CMD_W-1:0] command_byte;

  // leader window and command byte
  always_comb begin
    ok  = (frame.leader_interval >= cfg.leader_min) &&
          (frame.leader_interval <= cfg.leader_max);
    cmd = '0;
    if (ok) begin
      cmd[CMD_LOW-1:0] = frame.bit_store[CMD_LOW-1:0];
    end
    key_flag_next = key_flag ||
                    (ok && ((cmd == cfg.key_code_a) || (cmd == cfg.key_code_b)));
  end

  assign can_load = !valid || result.ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      key_flag <= 1'b0;
    end else begin
      if (load) begin
        valid    <= 1'b1;
        key_flag <= key_flag_next;
      end else if (result.ready) begin
        valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      leader_ok    <= ok;
      command_byte <= cmd;
    end
  end

  assign result.valid        = valid;
  assign result.leader_ok    = leader_ok;
  assign result.command_byte = command_byte;
  assign result.key_seen     = key_flag;

endmodule

// ----- dv/tb_ir_remote_pulse_decoder.sv -----
// self-checking testbench for the ir remote pulse decoder
`timescale 1ns / 1ps

module tb_ir_remote_pulse_decoder;
  import irpd_pkg::*;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = CFG_IDX_W'(7);

  localparam int FRAME_IVS   = FIRST_DATA_EDGE + DATA_BITS;
  localparam int ITEM_TARGET = 1150;
  localparam int DRAIN_WAIT  = 4;

  typedef struct packed {
    logic             leader_ok;
    logic [CMD_W-1:0] command_byte;
    logic             key_seen;
  } frame_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  irpd_item_if   item_bus ();
  irpd_result_if result_bus ();

  ir_remote_pulse_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_bus),
    .result    (result_bus)
  );

  // decoder shadow: configuration and frame state
  cfg_t                 shadow_cfg;
  logic                 rx_armed;
  logic [CNT_W-1:0]     rx_edges;
  logic [TICK_W-1:0]    rx_leader;
  logic [DATA_BITS-1:0] rx_bits;
  logic                 rx_key;

  frame_result_t frame_q[$];
  int            errors;
  int            items_sent;
  logic          pace_gaps;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // updates the shadow decoder with one accepted item
  function automatic void decode_item(input logic func, input logic [TICK_W-1:0] ticks);
    frame_result_t res;
    int            pos;
    if (func == FUNC_EDGE) begin
      if (!rx_armed) begin
        rx_armed = 1'b1;
      end else if (rx_edges < EDGE_DEPTH) begin
        pos = rx_edges;
        if (pos == 0) rx_leader = ticks;
        if (pos >= FIRST_DATA_EDGE && pos < FIRST_DATA_EDGE + DATA_BITS)
          rx_bits[pos - FIRST_DATA_EDGE] =
            (ticks >= shadow_cfg.one_min) && (ticks <= shadow_cfg.one_max);
        rx_edges = rx_edges + 1'b1;
      end
    end else begin
      res.leader_ok = (rx_leader >= shadow_cfg.leader_min) &&
                      (rx_leader <= shadow_cfg.leader_max);
      res.command_byte = '0;
      if (res.leader_ok) begin
        res.command_byte = CMD_W'(rx_bits);
        if (res.command_byte == shadow_cfg.key_code_a ||
            res.command_byte == shadow_cfg.key_code_b)
          rx_key = 1'b1;
      end
      res.key_seen = rx_key;
      rx_armed  = 1'b0;
      rx_edges  = '0;
      rx_leader = '0;
      frame_q.push_back(res);
    end
  endfunction

  // interval inside or outside [lo, hi], with the bounds and their neighbors often
  function automatic logic [TICK_W-1:0] pick_ticks(input logic [TICK_W-1:0] lo,
                                                   input logic [TICK_W-1:0] hi,
                                                   input logic want_in);
    logic [TICK_W-1:0] top;
    top = '1;
    if (want_in && lo <= hi) begin
      case ($urandom_range(7, 0))
        0: return lo;
        1: return hi;
        default: return TICK_W'($urandom_range(hi, lo));
      endcase
    end
    if (lo > 0 && (hi == top || $urandom_range(1, 0) == 0)) begin
      if ($urandom_range(3, 0) == 0) return lo - 1'b1;
      return TICK_W'($urandom_range(lo - 1'b1, 0));
    end
    if (hi < top) begin
      if ($urandom_range(3, 0) == 0) return hi + 1'b1;
      return TICK_W'($urandom_range(top, hi + 1'b1));
    end
    return TICK_W'($urandom);
  endfunction

  // one beat on the item channel; entered and left at a falling edge
  task automatic send_item(input logic func, input logic [TICK_W-1:0] ticks);
    while (pace_gaps && $urandom_range(99, 0) < 7) begin
      item_bus.valid <= 1'b0;
      @(negedge clk);
    end
    item_bus.valid          <= 1'b1;
    item_bus.func           <= func;
    item_bus.interval_ticks <= ticks;
    do @(posedge clk); while (!item_bus.ready);
    decode_item(func, ticks);
    items_sent++;
    @(negedge clk);
  endtask

  // sender goes quiet until every result is in and the pipeline is empty
  task automatic settle_decoder();
    item_bus.valid <= 1'b0;
    @(negedge clk);
    while (frame_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // register write, applied to the shadow at once since the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_LEADER_MIN: shadow_cfg.leader_min = data[TICK_W-1:0];
      REG_LEADER_MAX: shadow_cfg.leader_max = data[TICK_W-1:0];
      REG_ONE_MIN:    shadow_cfg.one_min    = data[TICK_W-1:0];
      REG_ONE_MAX:    shadow_cfg.one_max    = data[TICK_W-1:0];
      REG_KEY_CODE_A: shadow_cfg.key_code_a = data[CMD_W-1:0];
      REG_KEY_CODE_B: shadow_cfg.key_code_b = data[CMD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // full register set; key codes carry junk in the unused upper bits
  task automatic set_config(input logic [TICK_W-1:0] lmin, input logic [TICK_W-1:0] lmax,
                            input logic [TICK_W-1:0] omin, input logic [TICK_W-1:0] omax,
                            input logic [CMD_W-1:0] ka, input logic [CMD_W-1:0] kb);
    logic [CFG_DATA_W-1:0] data;
    settle_decoder();
    write_reg(REG_LEADER_MIN, lmin);
    write_reg(REG_LEADER_MAX, lmax);
    write_reg(REG_ONE_MIN, omin);
    write_reg(REG_ONE_MAX, omax);
    data = CFG_DATA_W'($urandom);
    data[CMD_W-1:0] = ka;
    write_reg(REG_KEY_CODE_A, data);
    data = CFG_DATA_W'($urandom);
    data[CMD_W-1:0] = kb;
    write_reg(REG_KEY_CODE_B, data);
  endtask

  // arm edge, n_iv intervals (leader first, command bits at the data slots), timeout
  task automatic send_frame(input logic [TICK_W-1:0] leader, input logic [CMD_W-1:0] cmd,
                            input int n_iv);
    int   k;
    logic want;
    send_item(FUNC_EDGE, TICK_W'($urandom));
    for (k = 0; k < n_iv; k++) begin
      if (k == 0) begin
        send_item(FUNC_EDGE, leader);
      end else begin
        want = $urandom_range(1, 0);
        if (k >= FIRST_DATA_EDGE && k - FIRST_DATA_EDGE < CMD_W)
          want = cmd[k - FIRST_DATA_EDGE];
        send_item(FUNC_EDGE, pick_ticks(shadow_cfg.one_min, shadow_cfg.one_max, want));
      end
    end
    send_item(FUNC_TIMEOUT, TICK_W'($urandom));
  endtask

  // one random frame: mostly well formed, some short, long or plain noise
  task automatic send_random_frame();
    int                sel;
    int                k;
    logic [CMD_W-1:0]  cmd;
    logic [TICK_W-1:0] leader;
    sel = $urandom_range(99, 0);
    case ($urandom_range(7, 0))
      0: cmd = shadow_cfg.key_code_a;
      1: cmd = shadow_cfg.key_code_b;
      default: cmd = CMD_W'($urandom);
    endcase
    leader = pick_ticks(shadow_cfg.leader_min, shadow_cfg.leader_max,
                        $urandom_range(9, 0) != 0);
    if (sel < 10) begin
      for (k = 0; k < int'($urandom_range(6, 1)); k++)
        send_item(logic'($urandom_range(1, 0)), TICK_W'($urandom));
    end else if (sel < 20) begin
      send_frame(leader, cmd, $urandom_range(FRAME_IVS - 1, 0));
    end else if (sel < 26) begin
      send_frame(leader, cmd, EDGE_DEPTH + $urandom_range(12, 1));
    end else begin
      send_frame(leader, cmd, FRAME_IVS + $urandom_range(2, 0));
    end
  endtask

  // short items at reset settings: unarmed timeouts, leader bounds, back-to-back results
  task automatic test_directed();
    send_item(FUNC_TIMEOUT, '0);
    send_item(FUNC_TIMEOUT, '1);
    send_item(FUNC_EDGE, '0);
    send_item(FUNC_EDGE, '1);
    send_item(FUNC_TIMEOUT, '0);
    send_item(FUNC_EDGE, '1);
    send_item(FUNC_EDGE, LEADER_MIN_RST);
    send_item(FUNC_TIMEOUT, '1);
    send_item(FUNC_EDGE, '0);
    send_item(FUNC_EDGE, LEADER_MAX_RST);
    send_item(FUNC_TIMEOUT, '0);
    send_item(FUNC_EDGE, '0);
    send_item(FUNC_EDGE, LEADER_MIN_RST - 1'b1);
    send_item(FUNC_TIMEOUT, '0);
    send_item(FUNC_EDGE, '0);
    send_item(FUNC_EDGE, LEADER_MAX_RST + 1'b1);
    send_item(FUNC_TIMEOUT, '0);
    send_item(FUNC_TIMEOUT, '1);
    send_item(FUNC_TIMEOUT, '0);
    send_item(FUNC_TIMEOUT, '1);
  endtask

  // key flag: ignored on a bad leader, set by either code, old bits kept on a short frame
  task automatic test_key_codes();
    send_frame(LEADER_MAX_RST + 17'd5000, KEY_CODE_A_RST, FRAME_IVS);
    send_frame(17'd12000, 8'h3c, FRAME_IVS);
    send_frame(17'd12000, KEY_CODE_A_RST, FRAME_IVS);
    send_frame(17'd11000, KEY_CODE_B_RST, FRAME_IVS);
    send_frame(17'd13000, 8'h00, FIRST_DATA_EDGE + 3);
    send_frame(17'd13000, 8'hff, FIRST_DATA_EDGE);
  endtask

  // edges past the store depth are dropped and the count stays put
  task automatic test_overlong_frames();
    send_frame(17'd12000, 8'ha5, EDGE_DEPTH);
    send_frame(17'd12000, 8'h5a, EDGE_DEPTH + 1);
    send_frame(17'd12500, 8'hc3, EDGE_DEPTH + 13);
    send_frame(17'd12500, 8'h0f, FRAME_IVS);
  endtask

  // window and key code extremes, plus writes to unused indexes
  task automatic test_config_extremes();
    int k;
    set_config('0, '1, '0, '1, 8'h00, 8'hff);
    write_reg(REG_SPARE_6, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_7, CFG_DATA_W'($urandom));
    for (k = 0; k < 3; k++) send_random_frame();
    send_frame('0, 8'hff, FRAME_IVS);
    send_frame('1, 8'h00, FRAME_IVS);
    set_config('1, '0, '0, '0, 8'hff, 8'h00);
    for (k = 0; k < 3; k++) send_random_frame();
    set_config('1, '1, '1, '1, 8'h80, 8'h01);
    send_frame('1, 8'h80, FRAME_IVS);
    send_frame('1, 8'h7f, FRAME_IVS);
    set_config('0, '0, 17'd100, 17'd100, 8'haa, 8'h55);
    send_frame('0, 8'haa, FRAME_IVS);
    send_item(FUNC_TIMEOUT, '1);
  endtask

  // random frames over changing settings until the item budget is spent
  task automatic test_random_traffic();
    int                phase;
    int                k;
    logic [TICK_W-1:0] lo;
    logic [TICK_W-1:0] omin;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      lo   = TICK_W'($urandom_range(20000, 0));
      omin = TICK_W'($urandom_range(5000, 0));
      if (phase % 6 == 5)
        set_config('0, '1, omin, omin + TICK_W'($urandom_range(800, 0)),
                   CMD_W'($urandom), CMD_W'($urandom));
      else
        set_config(lo, lo + TICK_W'($urandom_range(10000, 0)),
                   omin, omin + TICK_W'($urandom_range(1000, 0)),
                   CMD_W'($urandom), CMD_W'($urandom));
      // one long stretch with no gaps on either side
      pace_gaps = (phase != 2);
      for (k = 0; k < 8 && items_sent < ITEM_TARGET; k++) begin
        // sender holds off until every result is in
        if (phase == 1 && k == 4) settle_decoder();
        send_random_frame();
      end
      pace_gaps = 1'b1;
      phase++;
    end
  endtask

  // result sink with random stalls
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_bus.ready <= pace_gaps ? ($urandom_range(99, 0) >= 7) : 1'b1;
    end
  end

  // compare each result beat with the oldest expected frame
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected result beat leader_ok %0b command_byte %0h key_seen %0b",
                 $time, result_bus.leader_ok, result_bus.command_byte, result_bus.key_seen);
        errors++;
      end else begin
        want = frame_q.pop_front();
        if (result_bus.leader_ok !== want.leader_ok) begin
          $display("%0t: leader_ok expected %0b actual %0b",
                   $time, want.leader_ok, result_bus.leader_ok);
          errors++;
        end
        if (result_bus.command_byte !== want.command_byte) begin
          $display("%0t: command_byte expected %0h actual %0h",
                   $time, want.command_byte, result_bus.command_byte);
          errors++;
        end
        if (result_bus.key_seen !== want.key_seen) begin
          $display("%0t: key_seen expected %0b actual %0b",
                   $time, want.key_seen, result_bus.key_seen);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    #800000;
    $display("[ir_remote_pulse_decoder] ERROR");
    $finish;
  end

  // main sequence
  initial begin
    errors                  = 0;
    items_sent              = 0;
    pace_gaps               = 1'b1;
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    item_bus.valid          = 1'b0;
    item_bus.func           = FUNC_EDGE;
    item_bus.interval_ticks = '0;
    shadow_cfg.leader_min   = LEADER_MIN_RST;
    shadow_cfg.leader_max   = LEADER_MAX_RST;
    shadow_cfg.one_min      = ONE_MIN_RST;
    shadow_cfg.one_max      = ONE_MAX_RST;
    shadow_cfg.key_code_a   = KEY_CODE_A_RST;
    shadow_cfg.key_code_b   = KEY_CODE_B_RST;
    rx_armed                = 1'b0;
    rx_edges                = '0;
    rx_leader               = '0;
    rx_bits                 = '0;
    rx_key                  = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_key_codes();
    test_overlong_frames();
    test_config_extremes();
    test_random_traffic();

    settle_decoder();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[ir_remote_pulse_decoder] OK");
    end else begin
      $display("[ir_remote_pulse_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/irpd_pkg.sv
design/irpd_ifs.sv
design/irpd_cfg.sv
design/irpd_frame.sv
design/irpd_result.sv
design/ir_remote_pulse_decoder.sv
dv/tb_ir_remote_pulse_decoder.sv
